// ----- sv/btpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Balanced tile pixel mapper package
// Shared constants and register codes of the tile mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package btpm_pkg;

  // Default sizing of the frame and of the tile grid.
  localparam int DEF_MAX_DIM        = 4096;
  localparam int DEF_MAX_TILES_SIDE = 16;

  // Width of the pixel sample carried through.
  localparam int VALUE_W = 16;

  // Register values after reset.
  localparam int RST_FRAME_HEIGHT   = 1024;
  localparam int RST_FRAME_WIDTH    = 1024;
  localparam int RST_TILES_PER_SIDE = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_HEIGHT   = 2'd0,
    REG_FRAME_WIDTH    = 2'd1,
    REG_TILES_PER_SIDE = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

// ----- sv/btpm_div_step.sv -----
// ----------------------------------------------------------------------------
// Restoring division step
// Compares a partial remainder with the divisor shifted by a fixed amount
// and subtracts it when it fits, giving one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module btpm_div_step #(
  parameter int CW    = 12,
  parameter int DW    = 13,
  parameter int SHIFT = 0
) (
  input  wire logic [CW-1:0] rem_i,
  input  wire logic [DW-1:0] dvs_i,
  output logic      [CW-1:0] rem_o,
  output logic               bit_o
);

  localparam int XW = ((DW + SHIFT) > CW) ? (DW + SHIFT) : CW;

  logic [XW-1:0] rem_x;
  logic [XW-1:0] dvs_x;

  always_comb begin
    rem_x = XW'(rem_i);
    dvs_x = XW'(dvs_i) << SHIFT;
    bit_o = (rem_x >= dvs_x);
    rem_o = bit_o ? CW'(rem_x - dvs_x) : rem_i;
  end

endmodule

`default_nettype wire

// ----- sv/balanced_tile_pixel_mapper.sv -----
// ----------------------------------------------------------------------------
// Balanced tile pixel mapper
// Maps pixel coordinates onto a square grid of near-equal tiles.
// ----------------------------------------------------------------------------
// Pixels arrive on the slave stream, one beat per pixel, and each gives one
// beat on the master stream with the tile row, column and linear index, the
// offset inside the tile, the tile size and the sample passed through.
// Pixels outside the frame come out with tuser set and all data bits zero.
// The configuration port takes the frame height, frame width and tiles per
// side; any write of a known register starts a bit-serial divider that
// derives the base tile sizes, remainders and long-tile spans. The user
// must write configuration only while no pixel is in flight; the block
// does not enforce this. The pipeline has one selection stage, one
// restoring division stage per quotient bit, and the output register.
// One pixel is taken every cycle while the divider is idle and the
// receiver does not stall.
// After reset the divider runs once with the reset configuration, and
// s_axis_tready stays low until it has finished.
// When the receiver stalls, the pipeline fills up stage by stage and only
// then drops s_axis_tready; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module balanced_tile_pixel_mapper
  import btpm_pkg::*;
#(
  parameter int MAX_DIM        = DEF_MAX_DIM,
  parameter int MAX_TILES_SIDE = DEF_MAX_TILES_SIDE,
  localparam int CW       = $clog2(MAX_DIM),
  localparam int DW       = $clog2(MAX_DIM + 1),
  localparam int NW       = $clog2(MAX_TILES_SIDE + 1),
  localparam int TW       = (MAX_TILES_SIDE > 1) ? $clog2(MAX_TILES_SIDE) : 1,
  localparam int IW       = 2 * TW,
  localparam int CFG_W    = (DW > NW) ? DW : NW,
  localparam int IN_BITS  = 2 * CW + VALUE_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 4 * TW + 2 * CW + 2 * DW + VALUE_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // pixel_row, pixel_col, pixel_value
  input  wire logic [IN_W-1:0]      s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tile_row, tile_col, tile_index, inner_row, inner_col, tile_height,
  // tile_width, value_out
  output logic [OUT_W-1:0]          m_axis_tdata,
  // out_of_range
  output logic                      m_axis_tuser
);

  localparam int NS    = TW + 2;
  localparam int PW    = TW + NW;
  localparam int CNT_W = $clog2(DW);

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_DIV,
    CS_SPAN
  } cfg_state_e;

  typedef struct packed {
    logic [CW-1:0] rem;
    logic [DW-1:0] dvs;
    logic [TW-1:0] off;
    logic [TW-1:0] quo;
    logic [DW-1:0] size;
    logic          none;
  } axis_t;

  typedef struct packed {
    axis_t               r;
    axis_t               c;
    logic [VALUE_W-1:0]  value;
    logic                oor;
  } mid_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DW-1:0] frame_height_q;
  logic [DW-1:0] frame_width_q;
  logic [NW-1:0] tiles_q;
  logic          cfg_known;
  logic [DW-1:0] eff_h;
  logic [DW-1:0] eff_w;
  logic [NW-1:0] eff_t;

  assign cfg_known = cfg_we_i && (cfg_idx_i == REG_FRAME_HEIGHT ||
                                  cfg_idx_i == REG_FRAME_WIDTH ||
                                  cfg_idx_i == REG_TILES_PER_SIDE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_height_q <= DW'(RST_FRAME_HEIGHT);
      frame_width_q  <= DW'(RST_FRAME_WIDTH);
      tiles_q        <= NW'(RST_TILES_PER_SIDE);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_HEIGHT:   frame_height_q <= cfg_data_i[DW-1:0];
        REG_FRAME_WIDTH:    frame_width_q  <= cfg_data_i[DW-1:0];
        REG_TILES_PER_SIDE: tiles_q        <= cfg_data_i[NW-1:0];
        default: ;
      endcase
    end
  end

  // Oversized frames and tile counts saturate, and a tile count of zero counts as one.
  always_comb begin
    eff_h = (frame_height_q > DW'(MAX_DIM)) ? DW'(MAX_DIM) : frame_height_q;
    eff_w = (frame_width_q > DW'(MAX_DIM)) ? DW'(MAX_DIM) : frame_width_q;
    if (tiles_q == '0) begin
      eff_t = NW'(1);
    end else if (tiles_q > NW'(MAX_TILES_SIDE)) begin
      eff_t = NW'(MAX_TILES_SIDE);
    end else begin
      eff_t = tiles_q;
    end
  end

  // --------------------------------------------------------------------------
  // Bit-serial split of both axes into base size and remainder
  // --------------------------------------------------------------------------
  cfg_state_e     cs_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]  dvd_r_q, dvd_c_q;
  logic [NW:0]    rem_r_q, rem_c_q;
  logic [DW-1:0]  base_rows_q, base_cols_q;
  logic [TW-1:0]  extra_rows_q, extra_cols_q;
  logic [DW-1:0]  span_rows_q, span_cols_q;

  logic [NW:0]    rem_r_sh, rem_c_sh;
  logic           take_r, take_c;
  logic [DW:0]    base_r_inc, base_c_inc;
  logic [DW:0]    span_r_full, span_c_full;

  always_comb begin
    rem_r_sh    = {rem_r_q[NW-1:0], dvd_r_q[DW-1]};
    rem_c_sh    = {rem_c_q[NW-1:0], dvd_c_q[DW-1]};
    take_r      = (rem_r_sh >= {1'b0, eff_t});
    take_c      = (rem_c_sh >= {1'b0, eff_t});
    base_r_inc  = {1'b0, dvd_r_q} + (DW+1)'(1);
    base_c_inc  = {1'b0, dvd_c_q} + (DW+1)'(1);
    span_r_full = (DW+1)'(rem_r_q[TW-1:0]) * base_r_inc;
    span_c_full = (DW+1)'(rem_c_q[TW-1:0]) * base_c_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q         <= CS_LOAD;
      cnt_q        <= '0;
      dvd_r_q      <= '0;
      dvd_c_q      <= '0;
      rem_r_q      <= '0;
      rem_c_q      <= '0;
      base_rows_q  <= '0;
      base_cols_q  <= '0;
      extra_rows_q <= '0;
      extra_cols_q <= '0;
      span_rows_q  <= '0;
      span_cols_q  <= '0;
    end else if (cfg_known) begin
      cs_q <= CS_LOAD;
    end else begin
      case (cs_q)
        CS_LOAD: begin
          cnt_q   <= '0;
          dvd_r_q <= eff_h;
          dvd_c_q <= eff_w;
          rem_r_q <= '0;
          rem_c_q <= '0;
          cs_q    <= CS_DIV;
        end
        CS_DIV: begin
          cnt_q   <= cnt_q + CNT_W'(1);
          dvd_r_q <= {dvd_r_q[DW-2:0], take_r};
          dvd_c_q <= {dvd_c_q[DW-2:0], take_c};
          rem_r_q <= take_r ? (rem_r_sh - {1'b0, eff_t}) : rem_r_sh;
          rem_c_q <= take_c ? (rem_c_sh - {1'b0, eff_t}) : rem_c_sh;
          if (cnt_q == CNT_W'(DW - 1)) begin
            cs_q <= CS_SPAN;
          end
        end
        CS_SPAN: begin
          base_rows_q  <= dvd_r_q;
          base_cols_q  <= dvd_c_q;
          extra_rows_q <= rem_r_q[TW-1:0];
          extra_cols_q <= rem_c_q[TW-1:0];
          span_rows_q  <= span_r_full[DW-1:0];
          span_cols_q  <= span_c_full[DW-1:0];
          cs_q         <= CS_IDLE;
        end
        default: cs_q <= CS_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pixel pipeline
  // --------------------------------------------------------------------------
  function automatic axis_t axis_select(input logic [CW-1:0] p,
                                        input logic [DW-1:0] base,
                                        input logic [TW-1:0] extra,
                                        input logic [DW-1:0] span);
    axis_t         a;
    logic [DW-1:0] p_x;
    a   = '0;
    p_x = DW'(p);
    if (p_x < span) begin
      a.rem  = p;
      a.dvs  = base + DW'(1);
      a.size = base + DW'(1);
    end else if (base != '0) begin
      a.rem  = CW'(p_x - span);
      a.dvs  = base;
      a.off  = extra;
      a.size = base;
    end else begin
      a.none = 1'b1;
    end
    return a;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS-1:0] rdy;
  mid_t          mid_q [TW+1];
  mid_t          in_mid;
  logic          in_fire;
  logic [CW-1:0] in_row, in_col;

  assign rdy[NS-1] = !v_q[NS-1] || m_axis_tready;

  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  assign s_axis_tready = rdy[0] && (cs_q == CS_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_row       = s_axis_tdata[CW-1:0];
    in_col       = s_axis_tdata[2*CW-1:CW];
    in_mid.r     = axis_select(in_row, base_rows_q, extra_rows_q, span_rows_q);
    in_mid.c     = axis_select(in_col, base_cols_q, extra_cols_q, span_cols_q);
    in_mid.value = s_axis_tdata[2*CW+VALUE_W-1:2*CW];
    in_mid.oor   = (DW'(in_row) >= eff_h) || (DW'(in_col) >= eff_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_fire;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mid_q[0] <= in_mid;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= TW; k++) begin : g_div
    logic [CW-1:0] rem_r, rem_c;
    logic          bit_r, bit_c;
    mid_t          step_d;

    btpm_div_step #(
      .CW    (CW),
      .DW    (DW),
      .SHIFT (TW - k)
    ) u_step_r (
      .rem_i (mid_q[k-1].r.rem),
      .dvs_i (mid_q[k-1].r.dvs),
      .rem_o (rem_r),
      .bit_o (bit_r)
    );

    btpm_div_step #(
      .CW    (CW),
      .DW    (DW),
      .SHIFT (TW - k)
    ) u_step_c (
      .rem_i (mid_q[k-1].c.rem),
      .dvs_i (mid_q[k-1].c.dvs),
      .rem_o (rem_c),
      .bit_o (bit_c)
    );

    always_comb begin
      step_d              = mid_q[k-1];
      step_d.r.rem        = rem_r;
      step_d.c.rem        = rem_c;
      step_d.r.quo[TW-k]  = bit_r;
      step_d.c.quo[TW-k]  = bit_c;
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        mid_q[k] <= step_d;
      end
    end
  end

  // Output stage: tile numbers, linear index and zeroing of empty results.
  mid_t               last;
  logic [TW-1:0]      tile_r, tile_c;
  logic [PW-1:0]      idx_full;
  logic [CW-1:0]      inner_r, inner_c;
  logic [DW-1:0]      size_r, size_c;
  logic [VALUE_W-1:0] value_d;
  logic [OUT_W-1:0]   tdata_d;
  logic [OUT_W-1:0]   tdata_q;
  logic               tuser_q;

  always_comb begin
    last     = mid_q[TW];
    tile_r   = last.r.none ? '0 : last.r.off + last.r.quo;
    tile_c   = last.c.none ? '0 : last.c.off + last.c.quo;
    inner_r  = last.r.none ? '0 : last.r.rem;
    inner_c  = last.c.none ? '0 : last.c.rem;
    size_r   = last.r.none ? '0 : last.r.size;
    size_c   = last.c.none ? '0 : last.c.size;
    value_d  = last.value;
    idx_full = PW'(tile_r) * PW'(eff_t) + PW'(tile_c);
    tdata_d  = OUT_W'({value_d, size_c, size_r, inner_c, inner_r,
                       idx_full[IW-1:0], tile_c, tile_r});
    if (last.oor) begin
      tdata_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      tdata_q <= tdata_d;
      tuser_q <= last.oor;
    end
  end

  assign m_axis_tvalid = v_q[NS-1];
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cs_q != CS_IDLE) |-> !s_axis_tready)
    else $error("pixel accepted while tile sizes are being derived");

  a_write_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_known |=> (cs_q == CS_LOAD))
    else $error("register write did not restart the tile size derivation");

  a_div_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cs_q == CS_DIV) |-> (rem_r_q < {1'b0, eff_t}) && (rem_c_q < {1'b0, eff_t}))
    else $error("serial divider remainder not below the tile count");

  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("out-of-frame beat carries non-zero data");

endmodule

`default_nettype wire

// ----- verif/btpm_tile_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile mapper scoreboard
// Mirrors the configuration port, predicts the tile placement of every pixel
// beat taken on the slave stream and compares each master beat, field by
// field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module btpm_tile_checker
  import btpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [12:0]          cfg_data_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  // pixel_row, pixel_col, pixel_value
  input  logic [39:0]          s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  // tile_row, tile_col, tile_index, inner_row, inner_col, tile_height,
  // tile_width, value_out
  input  logic [87:0]          m_tdata_i,
  // out_of_range
  input  logic                 m_tuser_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  // One master beat, tuser on top of the padded tdata.
  typedef struct packed {
    logic        out_of_range;
    logic [5:0]  pad;
    logic [15:0] sample;
    logic [12:0] tile_width;
    logic [12:0] tile_height;
    logic [11:0] inner_col;
    logic [11:0] inner_row;
    logic [7:0]  tile_index;
    logic [3:0]  tile_col;
    logic [3:0]  tile_row;
  } tile_beat_t;

  logic [12:0] height_q;
  logic [12:0] width_q;
  logic [4:0]  tiles_q;

  tile_beat_t expected_tiles[$];

  function automatic int unsigned clamp_dim(logic [12:0] d);
    return (d > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(d);
  endfunction

  // The first remainder tiles along an axis are one pixel longer.
  function automatic void place_on_axis(input int unsigned p, input int unsigned d,
                                        input int unsigned t, output int unsigned tile,
                                        output int unsigned inner, output int unsigned size);
    int unsigned base, extra, span;
    base  = d / t;
    extra = d - base * t;
    span  = extra * (base + 1);
    if (p < span) begin
      tile  = p / (base + 1);
      inner = p % (base + 1);
      size  = base + 1;
    end else if (base != 0) begin
      tile  = extra + (p - span) / base;
      inner = (p - span) % base;
      size  = base;
    end else begin
      tile  = 0;
      inner = 0;
      size  = 0;
    end
  endfunction

  function automatic tile_beat_t map_pixel(logic [39:0] beat);
    int unsigned h, w, t, tr, ir, th, tc, ic, tw;
    tile_beat_t r;
    r = '0;
    h = clamp_dim(height_q);
    w = clamp_dim(width_q);
    if (tiles_q == 0) t = 1;
    else if (tiles_q > DEF_MAX_TILES_SIDE) t = DEF_MAX_TILES_SIDE;
    else t = tiles_q;
    if (beat[11:0] >= h || beat[23:12] >= w) begin
      r.out_of_range = 1'b1;
      return r;
    end
    place_on_axis(beat[11:0], h, t, tr, ir, th);
    place_on_axis(beat[23:12], w, t, tc, ic, tw);
    r.tile_row    = tr[3:0];
    r.tile_col    = tc[3:0];
    r.tile_index  = 8'(tr * t + tc);
    r.inner_row   = ir[11:0];
    r.inner_col   = ic[11:0];
    r.tile_height = th[12:0];
    r.tile_width  = tw[12:0];
    r.sample      = beat[39:24];
    return r;
  endfunction

  function automatic string fmt_beat(tile_beat_t b);
    return $sformatf("oor=%0d tr=%0d tc=%0d idx=%0d ir=%0d ic=%0d th=%0d tw=%0d val=%h pad=%h",
                     b.out_of_range, b.tile_row, b.tile_col, b.tile_index, b.inner_row,
                     b.inner_col, b.tile_height, b.tile_width, b.sample, b.pad);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tile_beat_t got, want;
    logic bad;
    if (!rst_ni) begin
      height_q = 13'(RST_FRAME_HEIGHT);
      width_q  = 13'(RST_FRAME_WIDTH);
      tiles_q  = 5'(RST_TILES_PER_SIDE);
      expected_tiles.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_HEIGHT:   height_q = cfg_data_i;
          REG_FRAME_WIDTH:    width_q  = cfg_data_i;
          REG_TILES_PER_SIDE: tiles_q  = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tuser_i, m_tdata_i};
        if (expected_tiles.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: beat with nothing expected: %s", $realtime, fmt_beat(got));
          fail_count_o++;
        end else begin
          want = expected_tiles.pop_front();
          bad = (got.out_of_range !== want.out_of_range) || (got.pad !== want.pad) ||
                (got.sample !== want.sample) || (got.tile_width !== want.tile_width) ||
                (got.tile_height !== want.tile_height) ||
                (got.inner_col !== want.inner_col) || (got.inner_row !== want.inner_row) ||
                (got.tile_index !== want.tile_index) || (got.tile_col !== want.tile_col) ||
                (got.tile_row !== want.tile_row);
          if (bad) begin
            if (fail_count_o < 10) begin
              $display("%0t: tile beat mismatch", $realtime);
              $display("  expected %s", fmt_beat(want));
              $display("  actual   %s", fmt_beat(got));
            end
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_tiles.insert(expected_tiles.size(), map_pixel(s_tdata_i));
      pending_o = expected_tiles.size();
    end
  end

endmodule

// ----- verif/tb_balanced_tile_pixel_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile mapper testbench
// Drives pixel beats and configuration writes into the tile mapper, with a
// directed opening and randomised phases under varying back-pressure; the
// scoreboard beside the block does all the checking.
// ----------------------------------------------------------------------------

module tb_balanced_tile_pixel_mapper;
  import btpm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_PIXELS = 250;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [12:0]          cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // pixel_row, pixel_col, pixel_value
  logic [39:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // tile_row, tile_col, tile_index, inner_row, inner_col, tile_height,
  // tile_width, value_out
  logic [87:0]          m_axis_tdata;
  // out_of_range
  logic                 m_axis_tuser;

  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_off_req;
  int unsigned frame_rows;
  int unsigned frame_cols;

  balanced_tile_pixel_mapper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  btpm_tile_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int   hold_left;
    logic hold_used;
    hold_left     = 0;
    hold_used     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic int unsigned clamp_dim(logic [12:0] d);
    return (d > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(d);
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == REG_FRAME_HEIGHT) frame_rows = clamp_dim(data);
    if (idx == REG_FRAME_WIDTH)  frame_cols = clamp_dim(data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input logic [11:0] row, input logic [11:0] col,
                            input logic [15:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sample, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly pixels inside the frame, some right on its edge, some anywhere.
  task automatic send_random_pixel();
    logic [11:0] row, col;
    int pick;
    pick = $urandom_range(99);
    if (frame_rows == 0 || frame_cols == 0 || pick < 10) begin
      row = 12'($urandom);
      col = 12'($urandom);
    end else if (pick < 16) begin
      row = 12'(frame_rows - $urandom_range(1));
      col = 12'(frame_cols - $urandom_range(1));
    end else begin
      row = 12'($urandom_range(frame_rows - 1));
      col = 12'($urandom_range(frame_cols - 1));
    end
    send_pixel(row, col, 16'($urandom));
  endtask

  // Registers may only change once every pixel has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(4))
      0: return 13'($urandom);
      1: return 13'($urandom_range(4096, 1));
      2: return 13'($urandom_range(48, 1));
      3: return $urandom_range(1) ? 13'd1 : 13'd4096;
      default: return 13'($urandom_range(600, 1));
    endcase
  endfunction

  function automatic logic [12:0] pick_tiles();
    logic [4:0] t;
    if ($urandom_range(2) == 0) t = 5'($urandom);
    else t = 5'($urandom_range(16, 1));
    // Upper data bits are not part of the register.
    return {8'($urandom), t};
  endfunction

  initial begin : stimulus
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_FRAME_HEIGHT;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;
    frame_rows     = RST_FRAME_HEIGHT;
    frame_cols     = RST_FRAME_WIDTH;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset geometry: field extremes and the frame border.
    send_pixel(12'd0, 12'd0, 16'h0000);
    send_pixel(12'd1023, 12'd1023, 16'hffff);
    send_pixel(12'd1024, 12'd0, 16'h1234);
    send_pixel(12'd0, 12'd1024, 16'hffff);
    send_pixel(12'd4095, 12'd4095, 16'hffff);
    send_pixel(12'd255, 12'd256, 16'ha5a5);

    // Oversized frame and tile count saturate.
    drain();
    write_reg(REG_FRAME_HEIGHT, 13'd8191);
    write_reg(REG_FRAME_WIDTH, 13'd4096);
    write_reg(REG_TILES_PER_SIDE, 13'd31);
    send_pixel(12'd4095, 12'd4095, 16'h5a5a);
    send_pixel(12'd256, 12'd255, 16'h0001);

    // Empty frame, and a tile count of zero.
    drain();
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    write_reg(REG_FRAME_WIDTH, 13'd5);
    write_reg(REG_TILES_PER_SIDE, 13'd0);
    send_pixel(12'd0, 12'd0, 16'hbeef);
    drain();
    write_reg(REG_FRAME_HEIGHT, 13'd7);
    send_pixel(12'd6, 12'd4, 16'h0f0f);

    // More tiles than pixels along both axes.
    drain();
    write_reg(REG_FRAME_HEIGHT, 13'd5);
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_TILES_PER_SIDE, 13'd16);
    send_pixel(12'd4, 12'd2, 16'h7777);
    send_pixel(12'd0, 12'd0, 16'h8888);
    send_pixel(12'd2, 12'd1, 16'h9999);

    // Single-pixel frame; the spare register index must change nothing.
    drain();
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_TILES_PER_SIDE, 13'd1);
    write_reg(CFG_IDX_SPARE, 13'h1fff);
    send_pixel(12'd0, 12'd0, 16'hc3c3);
    send_pixel(12'd0, 12'd1, 16'h3c3c);
    send_pixel(12'd1, 12'd0, 16'h0ff0);

    // Long and short tiles on either side of the remainder boundary.
    drain();
    write_reg(REG_FRAME_HEIGHT, 13'd17);
    write_reg(REG_FRAME_WIDTH, 13'd4095);
    write_reg(REG_TILES_PER_SIDE, 13'd16);
    send_pixel(12'd1, 12'd3839, 16'h1111);
    send_pixel(12'd2, 12'd3840, 16'h2222);
    send_pixel(12'd16, 12'd4094, 16'h3333);
    send_pixel(12'd17, 12'd0, 16'h4444);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      write_reg(REG_TILES_PER_SIDE, pick_tiles());
      write_reg(REG_FRAME_HEIGHT, pick_dim());
      write_reg(REG_FRAME_WIDTH, pick_dim());
      if ($urandom_range(3) == 0) write_reg(CFG_IDX_SPARE, 13'($urandom));
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
      endcase
      // With the sender flat out, a long stall backs the pipeline up.
      if (ph == 4) hold_off_req = 1'b1;
      repeat (PHASE_PIXELS) send_random_pixel();
    end

    drain();
    repeat (24) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
